[rtl/wsu_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker package
// Shared types, status codes, opcodes and header constants.
// ----------------------------------------------------------------------------
package wsu_pkg;

   localparam int OUT_LEN_W = 63;

   // header length field codes
   localparam logic [6:0] LEN7_MAX   = 7'd125;
   localparam logic [6:0] LEN16_CODE = 7'd126;

   // opcodes that the block knows
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   // header byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [2:0] {
      ST_PAYLOAD = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_CLOSE   = 3'd2,
      ST_REJECT  = 3'd3,
      ST_TRUNC   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_PAY  = 3'd4,
      PH_SKIP = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      status_type           out_status;
      logic                 out_end;
      logic [3:0]           out_opcode;
      logic                 out_fin;
      logic                 out_masked;
      logic [OUT_LEN_W-1:0] out_length;
   } result_type;

endpackage

[rtl/wsu_channels.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker channels
// Valid/ready channels for raw input bytes and for result beats.
// ----------------------------------------------------------------------------
interface wsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface wsu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    out_byte;
   wsu_pkg::status_type           out_status;
   logic                          out_end;
   logic [3:0]                    out_opcode;
   logic                          out_fin;
   logic                          out_masked;
   logic [wsu_pkg::OUT_LEN_W-1:0] out_length;

   modport source (output valid, output out_byte, output out_status, output out_end,
                   output out_opcode, output out_fin, output out_masked,
                   output out_length, input ready);
   modport sink   (input valid, input out_byte, input out_status, input out_end,
                   input out_opcode, input out_fin, input out_masked,
                   input out_length, output ready);
endinterface

[rtl/websocket_frame_unmasker_core.sv]
// ----------------------------------------------------------------------------
// WebSocket frame unmasker core
// Parses one frame per received buffer and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries the received buffer one byte per beat; in_last marks the
//   final byte and always returns the parser to the first header byte.
//   rsp_bus carries zero or one result beat per input beat: a payload byte
//   XORed with the mask key, or a status (empty frame, close, rejected
//   opcode, truncated) together with the frame's header fields.
//   A result is registered and appears on rsp_bus in the cycle after its input beat is accepted.
//   Throughput: one input beat per cycle while req_bus is ready; the header state and the payload
//   counter update once per accepted byte.
//   A result register parts the two sides; req_bus stays ready while that
//   register is empty or being drained, so a stalled receiver holds off the
//   sender only once a result is waiting.
//   Reset clears the result register and puts the parser at the first
//   header byte of a new buffer.
//   LENGTH_BITS sets how many low bits of the decoded length are kept, at most 63.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_core #(
   parameter int LENGTH_BITS = 64
) (
   input logic         clock,
   input logic         reset,
   wsu_req_if.sink     req_bus,
   wsu_rsp_if.source   rsp_bus
);

   logic                rsp_valid_ff;
   wsu_pkg::result_type rsp_data_ff;
   logic                accept;
   logic                res_valid;
   wsu_pkg::result_type res;
   logic                load_ok;

   assign load_ok       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = load_ok;
   assign accept        = req_bus.valid && load_ok;

   wsu_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_bus.in_byte),
      .in_last   (req_bus.in_last),
      .res_valid (res_valid),
      .res       (res)
   );

   // advance the result register whenever it is empty or its beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_ok) begin
         rsp_valid_ff <= accept && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_byte   = rsp_data_ff.out_byte;
   assign rsp_bus.out_status = rsp_data_ff.out_status;
   assign rsp_bus.out_end    = rsp_data_ff.out_end;
   assign rsp_bus.out_opcode = rsp_data_ff.out_opcode;
   assign rsp_bus.out_fin    = rsp_data_ff.out_fin;
   assign rsp_bus.out_masked = rsp_data_ff.out_masked;
   assign rsp_bus.out_length = rsp_data_ff.out_length;

endmodule

[rtl/wsu_parser.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header state and computes, per accepted byte, the next state
// and at most one result beat.
// ----------------------------------------------------------------------------
module wsu_parser #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                res_valid,
   output wsu_pkg::result_type res
);

   localparam int LenW    = (LENGTH_BITS >= 63) ? 63 : LENGTH_BITS;
   localparam int OutLenW = wsu_pkg::OUT_LEN_W;

   wsu_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [3:0]         hdr_idx_ff, hdr_idx_in, hdr_dec;
   logic [3:0]         opcode_ff, opcode_in;
   logic               fin_ff, fin_in;
   logic               masked_ff, masked_in;
   logic [LenW-1:0]    length_ff, length_in;
   logic [31:0]        key_ff, key_in;
   logic [LenW-1:0]    count_ff, count_in, count_inc;
   logic [7:0]         key_byte;
   logic               mid_frame;

   assign hdr_dec   = hdr_idx_ff - 4'd1;
   assign count_inc = count_ff + LenW'(1);

   // next state
   always_comb begin
      phase_step = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      opcode_in  = opcode_ff;
      fin_in     = fin_ff;
      masked_in  = masked_ff;
      length_in  = length_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      unique case (phase_ff)
         wsu_pkg::PH_HDR0: begin
            fin_in     = in_byte[7];
            opcode_in  = in_byte[3:0];
            masked_in  = 1'b0;
            length_in  = '0;
            key_in     = '0;
            count_in   = '0;
            hdr_idx_in = '0;
            if (in_byte[3:0] == wsu_pkg::OP_TEXT || in_byte[3:0] == wsu_pkg::OP_BINARY) begin
               phase_step = wsu_pkg::PH_HDR1;
            end else begin
               phase_step = wsu_pkg::PH_SKIP;
            end
         end
         wsu_pkg::PH_HDR1: begin
            masked_in = in_byte[7];
            if (in_byte[6:0] <= wsu_pkg::LEN7_MAX) begin
               length_in  = LenW'(in_byte[6:0]);
               hdr_idx_in = wsu_pkg::KEY_BYTES;
               phase_step = wsu_pkg::PH_KEY;
            end else if (in_byte[6:0] == wsu_pkg::LEN16_CODE) begin
               hdr_idx_in = wsu_pkg::EXT16_BYTES;
               phase_step = wsu_pkg::PH_EXT;
            end else begin
               hdr_idx_in = wsu_pkg::EXT64_BYTES;
               phase_step = wsu_pkg::PH_EXT;
            end
         end
         wsu_pkg::PH_EXT: begin
            // keep only the low bits of a long length
            length_in = {length_ff[LenW-9:0], in_byte};
            if (hdr_dec == 4'd0) begin
               hdr_idx_in = wsu_pkg::KEY_BYTES;
               phase_step = wsu_pkg::PH_KEY;
            end else begin
               hdr_idx_in = hdr_dec;
            end
         end
         wsu_pkg::PH_KEY: begin
            key_in     = {key_ff[23:0], in_byte};
            hdr_idx_in = hdr_dec;
            if (hdr_dec == 4'd0) begin
               phase_step = (length_ff == '0) ? wsu_pkg::PH_SKIP : wsu_pkg::PH_PAY;
            end
         end
         wsu_pkg::PH_PAY: begin
            count_in = count_inc;
            if (count_inc == length_ff) begin
               phase_step = wsu_pkg::PH_SKIP;
            end
         end
         default: begin
            phase_step = wsu_pkg::PH_SKIP;
         end
      endcase

      phase_in = phase_step;
      if (in_last) begin
         phase_in   = wsu_pkg::PH_HDR0;
         hdr_idx_in = '0;
      end
   end

   assign mid_frame = (phase_step == wsu_pkg::PH_HDR1) || (phase_step == wsu_pkg::PH_EXT) ||
                      (phase_step == wsu_pkg::PH_KEY)  || (phase_step == wsu_pkg::PH_PAY);

   always_comb begin
      unique case (count_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // result beat
   always_comb begin
      res_valid      = 1'b0;
      res.out_byte   = '0;
      res.out_status = wsu_pkg::ST_PAYLOAD;
      res.out_end    = 1'b0;
      res.out_opcode = opcode_in;
      res.out_fin    = fin_in;
      res.out_masked = masked_in;
      res.out_length = OutLenW'(length_in);
      unique case (phase_ff)
         wsu_pkg::PH_HDR0: begin
            if (phase_step == wsu_pkg::PH_SKIP) begin
               res_valid      = 1'b1;
               res.out_end    = 1'b1;
               res.out_status = (in_byte[3:0] == wsu_pkg::OP_CLOSE) ?
                                wsu_pkg::ST_CLOSE : wsu_pkg::ST_REJECT;
            end
         end
         wsu_pkg::PH_KEY: begin
            if (phase_step == wsu_pkg::PH_SKIP) begin
               res_valid      = 1'b1;
               res.out_end    = 1'b1;
               res.out_status = wsu_pkg::ST_EMPTY;
            end
         end
         wsu_pkg::PH_PAY: begin
            res_valid    = 1'b1;
            res.out_byte = in_byte ^ key_byte;
            res.out_end  = (phase_step == wsu_pkg::PH_SKIP);
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      // buffer ended inside a frame: drop any payload byte, report truncation
      if (in_last && mid_frame) begin
         res_valid      = 1'b1;
         res.out_byte   = '0;
         res.out_status = wsu_pkg::ST_TRUNC;
         res.out_end    = 1'b1;
      end
      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsu_pkg::PH_HDR0;
         hdr_idx_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         length_ff <= length_in;
         key_ff    <= key_in;
         count_ff  <= count_in;
      end
   end

endmodule

[tb/tb_websocket_frame_unmasker_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame unmasker core testbench
// Feeds received buffers byte by byte. It starts with a short table of
// directed frames, then sends random frames and noise. The testbench keeps
// its own copy of the parser to predict every status and unmasked payload
// beat, and it scoreboards the result channel against that prediction.
// ----------------------------------------------------------------------------
module tb_websocket_frame_unmasker_core;

   localparam int                  LEN_BITS    = 64;
   localparam int                  LEN_KEPT    = (LEN_BITS >= 63) ? 63 : LEN_BITS;
   localparam logic [63:0]         LEN_KEEP    = (64'd1 << LEN_KEPT) - 64'd1;
   localparam int                  ITEM_TARGET = 1450;
   localparam int                  HOLD_AT     = 500;
   localparam int                  HOLD_CYCLES = 300;
   localparam int                  CYCLE_LIMIT = 400000;
   localparam wsu_pkg::result_type NO_BEAT     = '0;

   typedef struct {
      logic [7:0]          data;
      logic                last;
      logic                typed;
      wsu_pkg::result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   wsu_req_if req_if();
   wsu_rsp_if rsp_if();

   websocket_frame_unmasker_core #(.LENGTH_BITS(LEN_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // parser copy used for prediction
   wsu_pkg::phase_type ph        = wsu_pkg::PH_HDR0;
   logic [3:0]         hdr_left  = '0;
   logic [3:0]         fr_op     = '0;
   logic               fr_fin    = 1'b0;
   logic               fr_masked = 1'b0;
   logic [63:0]        fr_len    = '0;
   logic [31:0]        fr_key    = '0;
   logic [63:0]        pay_cnt   = '0;

   wsu_pkg::result_type expected_beats[$];
   logic                beat_typed;
   wsu_pkg::result_type beat_want;
   bit                  steady = 1'b0;
   int                  beats_in = 0;
   int                  errors = 0;
   int                  by_status[5] = '{default: 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic wsu_pkg::result_type status_beat(wsu_pkg::status_type st,
                                                       logic [3:0] op, logic fin,
                                                       logic masked, logic [62:0] len);
      wsu_pkg::result_type r;
      r            = '0;
      r.out_status = st;
      r.out_end    = 1'b1;
      r.out_opcode = op;
      r.out_fin    = fin;
      r.out_masked = masked;
      r.out_length = len;
      return r;
   endfunction

   function automatic stim_row_type plain(logic [7:0] data, logic last);
      stim_row_type s;
      s = '{data, last, 1'b0, NO_BEAT};
      return s;
   endfunction

   function automatic stim_row_type typed_row(logic [7:0] data, logic last,
                                              wsu_pkg::result_type want);
      stim_row_type s;
      s = '{data, last, 1'b1, want};
      return s;
   endfunction

   // advance the parser copy by one byte; have is set when a beat results
   function automatic void predict_frame(input logic [7:0] b, input logic last,
                                         output logic have, output wsu_pkg::result_type r);
      logic [6:0] code;
      have = 1'b0;
      r    = '0;
      case (ph)
         wsu_pkg::PH_HDR0: begin
            fr_fin    = b[7];
            fr_op     = b[3:0];
            fr_masked = 1'b0;
            fr_len    = '0;
            fr_key    = '0;
            pay_cnt   = '0;
            hdr_left  = '0;
            if (fr_op == wsu_pkg::OP_CLOSE) begin
               have = 1'b1; r.out_status = wsu_pkg::ST_CLOSE; r.out_end = 1'b1;
               ph = wsu_pkg::PH_SKIP;
            end else if (fr_op == wsu_pkg::OP_TEXT || fr_op == wsu_pkg::OP_BINARY) begin
               ph = wsu_pkg::PH_HDR1;
            end else begin
               have = 1'b1; r.out_status = wsu_pkg::ST_REJECT; r.out_end = 1'b1;
               ph = wsu_pkg::PH_SKIP;
            end
         end
         wsu_pkg::PH_HDR1: begin
            code      = b[6:0];
            fr_masked = b[7];
            if (code <= wsu_pkg::LEN7_MAX) begin
               fr_len   = {57'd0, code} & LEN_KEEP;
               hdr_left = wsu_pkg::KEY_BYTES;
               ph       = wsu_pkg::PH_KEY;
            end else if (code == wsu_pkg::LEN16_CODE) begin
               hdr_left = wsu_pkg::EXT16_BYTES;
               ph       = wsu_pkg::PH_EXT;
            end else begin
               hdr_left = wsu_pkg::EXT64_BYTES;
               ph       = wsu_pkg::PH_EXT;
            end
         end
         wsu_pkg::PH_EXT: begin
            fr_len = {fr_len[55:0], b} & LEN_KEEP;
            if (hdr_left != 0) hdr_left--;
            if (hdr_left == 0) begin
               hdr_left = wsu_pkg::KEY_BYTES;
               ph       = wsu_pkg::PH_KEY;
            end
         end
         wsu_pkg::PH_KEY: begin
            fr_key = {fr_key[23:0], b};
            if (hdr_left != 0) hdr_left--;
            if (hdr_left == 0) begin
               if (fr_len == 0) begin
                  have = 1'b1; r.out_status = wsu_pkg::ST_EMPTY; r.out_end = 1'b1;
                  ph = wsu_pkg::PH_SKIP;
               end else begin
                  ph = wsu_pkg::PH_PAY;
               end
            end
         end
         wsu_pkg::PH_PAY: begin
            // key bytes are applied most significant first
            r.out_byte = b ^ fr_key[8 * (3 - int'(pay_cnt[1:0])) +: 8];
            pay_cnt++;
            have = 1'b1;
            r.out_status = wsu_pkg::ST_PAYLOAD;
            if (pay_cnt >= fr_len) begin
               r.out_end = 1'b1;
               ph = wsu_pkg::PH_SKIP;
            end
         end
         default: ph = wsu_pkg::PH_SKIP;
      endcase
      if (last) begin
         if (ph == wsu_pkg::PH_HDR1 || ph == wsu_pkg::PH_EXT || ph == wsu_pkg::PH_KEY ||
             ph == wsu_pkg::PH_PAY) begin
            have = 1'b1; r.out_status = wsu_pkg::ST_TRUNC; r.out_end = 1'b1; r.out_byte = '0;
         end
         ph       = wsu_pkg::PH_HDR0;
         hdr_left = '0;
      end
      r.out_opcode = fr_op;
      r.out_fin    = fr_fin;
      r.out_masked = fr_masked;
      r.out_length = fr_len[62:0];
   endfunction

   // scoreboard: check result beats first, then record the accepted input beat
   always @(posedge clock) begin
      logic                have;
      wsu_pkg::result_type want;
      wsu_pkg::result_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.out_byte   = rsp_if.out_byte;
            got.out_status = rsp_if.out_status;
            got.out_end    = rsp_if.out_end;
            got.out_opcode = rsp_if.out_opcode;
            got.out_fin    = rsp_if.out_fin;
            got.out_masked = rsp_if.out_masked;
            got.out_length = rsp_if.out_length;
            if (expected_beats.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result beat byte=%h status=%0d",
                           $realtime, got.out_byte, got.out_status);
            end else begin
               want = expected_beats.pop_front();
               if (int'(want.out_status) < 5) by_status[int'(want.out_status)]++;
               if (got.out_byte !== want.out_byte || got.out_status !== want.out_status ||
                   got.out_end !== want.out_end || got.out_opcode !== want.out_opcode ||
                   got.out_fin !== want.out_fin || got.out_masked !== want.out_masked ||
                   got.out_length !== want.out_length) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: result mismatch (expected / actual)", $realtime);
                     $display("   byte %h/%h status %0d/%0d end %b/%b opcode %h/%h",
                              want.out_byte, got.out_byte, want.out_status,
                              got.out_status, want.out_end, got.out_end,
                              want.out_opcode, got.out_opcode);
                     $display("   fin %b/%b masked %b/%b length %h/%h",
                              want.out_fin, got.out_fin, want.out_masked, got.out_masked,
                              want.out_length, got.out_length);
                  end
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_frame(req_if.in_byte, req_if.in_last, have, want);
            if (beat_typed) begin
               have = 1'b1;
               want = beat_want;
            end
            if (have) expected_beats = {expected_beats, want};
            beats_in++;
         end
      end
   end

   // receiver: random stalls, one long hold-off once enough beats went in
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && beats_in >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   initial begin
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_beat(input logic [7:0] data, input logic last, input logic typed,
                            input wsu_pkg::result_type want);
      while (!steady && $urandom_range(99) < 15) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= data;
      req_if.in_last <= last;
      beat_typed     <= typed;
      beat_want      <= want;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      @(negedge clock);
   endtask

   // drop valid and hold until every expected beat has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_beats.size() != 0) @(negedge clock);
   endtask

   initial begin
      stim_row_type dir_rows[$];
      logic [7:0]   frame_bytes[$];
      logic [63:0]  plen;
      logic [3:0]   op;
      logic         mbit;
      bit           paused;
      int           kind, sel, cut, npay, n_items, n_frames;

      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      req_if.in_last = 1'b0;
      beat_typed     = 1'b0;
      beat_want      = NO_BEAT;
      reset          = 1'b1;
      paused         = 1'b0;
      n_frames       = 0;

      // close frame, then a discarded byte ending the buffer
      dir_rows = {dir_rows, typed_row(8'h88, 1'b0,
                  status_beat(wsu_pkg::ST_CLOSE, wsu_pkg::OP_CLOSE, 1'b1, 1'b0, '0))};
      dir_rows = {dir_rows, plain(8'h55, 1'b1)};
      // ping is rejected
      dir_rows = {dir_rows, typed_row(8'h09, 1'b1,
                  status_beat(wsu_pkg::ST_REJECT, 4'h9, 1'b0, 1'b0, '0))};
      // masked binary frame of zero length
      dir_rows = {dir_rows, plain(8'h82, 1'b0)};
      dir_rows = {dir_rows, plain(8'h80, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b0)};
      dir_rows = {dir_rows, typed_row(8'h00, 1'b1,
                  status_beat(wsu_pkg::ST_EMPTY, wsu_pkg::OP_BINARY, 1'b1, 1'b1, '0))};
      // text fragment with 16-bit length 2, buffer ends on the last payload byte
      dir_rows = {dir_rows, plain(8'h01, 1'b0)};
      dir_rows = {dir_rows, plain(8'hFE, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b0)};
      dir_rows = {dir_rows, plain(8'h02, 1'b0)};
      dir_rows = {dir_rows, plain(8'hFF, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b0)};
      dir_rows = {dir_rows, plain(8'hAA, 1'b0)};
      dir_rows = {dir_rows, plain(8'h55, 1'b0)};
      dir_rows = {dir_rows, plain(8'hFF, 1'b0)};
      dir_rows = {dir_rows, plain(8'h00, 1'b1)};
      // 64-bit length cut short inside the extended length
      dir_rows = {dir_rows, plain(8'h81, 1'b0)};
      dir_rows = {dir_rows, plain(8'h7F, 1'b0)};
      repeat (5) dir_rows = {dir_rows, plain(8'hFF, 1'b0)};
      dir_rows = {dir_rows, typed_row(8'hFF, 1'b1,
                  status_beat(wsu_pkg::ST_TRUNC, wsu_pkg::OP_TEXT, 1'b1, 1'b0,
                              63'hFFFF_FFFF_FFFF))};
      n_items = dir_rows.size();

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i])
         send_beat(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
      drain();

      while (n_items < ITEM_TARGET) begin
         frame_bytes.delete();
         kind = $urandom_range(99);
         if (kind < 8) begin
            // noise buffer
            repeat ($urandom_range(1, 8)) frame_bytes = {frame_bytes, 8'($urandom)};
         end else begin
            if (kind < 14)
               op = wsu_pkg::OP_CLOSE;
            else if (kind < 20)
               op = 4'($urandom);
            else
               op = $urandom_range(1) ? wsu_pkg::OP_TEXT : wsu_pkg::OP_BINARY;
            mbit = 1'($urandom);
            frame_bytes = {frame_bytes, {1'($urandom), 3'($urandom), op}};
            sel = $urandom_range(9);
            if (sel < 6) begin
               plen = (sel < 4) ? $urandom_range(0, 12) : $urandom_range(0, 125);
               frame_bytes = {frame_bytes, {mbit, 7'(plen)}};
            end else if (sel < 9) begin
               plen = $urandom_range(1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
               frame_bytes = {frame_bytes, {mbit, wsu_pkg::LEN16_CODE}};
               frame_bytes = {frame_bytes, plen[15:8]};
               frame_bytes = {frame_bytes, plen[7:0]};
            end else begin
               frame_bytes = {frame_bytes, {mbit, 7'h7F}};
               plen = '0;
               sel  = $urandom_range(1);
               for (int k = 0; k < 8; k++) begin
                  frame_bytes = {frame_bytes,
                                 sel ? ((k == 7) ? 8'($urandom_range(0, 40)) : 8'h00)
                                     : 8'($urandom)};
                  plen = {plen[55:0], frame_bytes[frame_bytes.size() - 1]};
               end
               plen = plen & LEN_KEEP;
            end
            repeat (4) frame_bytes = {frame_bytes, 8'($urandom)};
            npay = (plen <= 40) ? int'(plen) : $urandom_range(0, 40);
            repeat (npay) frame_bytes = {frame_bytes, 8'($urandom)};
            // trailing bytes are ignored by the block
            repeat ($urandom_range(0, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
            if ($urandom_range(99) < 12) begin
               cut = $urandom_range(0, frame_bytes.size() - 1);
               frame_bytes = frame_bytes[0:cut];
            end
         end
         foreach (frame_bytes[i])
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_BEAT);
         n_items += frame_bytes.size();
         n_frames++;
         if (!paused && n_items > 700) begin
            drain();
            paused = 1'b1;
         end
         steady <= (n_items >= 900 && n_items < 1150);
      end

      drain();
      repeat (5) @(negedge clock);
      $display("Sent %0d buffers, %0d input beats; results: %0d payload, %0d empty,",
               n_frames + 5, beats_in, by_status[0], by_status[1]);
      $display("%0d close, %0d rejected, %0d truncated; %0d errors",
               by_status[2], by_status[3], by_status[4], errors);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
